// ----- rtl/core/csr_pkg.sv -----
// ----------------------------------------------------------------------------
// Circle and square relation package
// Shared widths, result codes and helper types for the circle versus square
// classifier.
// ----------------------------------------------------------------------------
package csr_pkg;

    localparam int COORD_BITS = 16;
    localparam int LEN_BITS   = COORD_BITS - 1;
    localparam int EXT_BITS   = COORD_BITS + 1;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int SQ_BITS    = 2 * DIFF_BITS;
    localparam int DIST_BITS  = SQ_BITS + 1;
    localparam int R2_BITS    = 2 * LEN_BITS;
    localparam int NUM_PTS    = 5;
    localparam int NUM_EXTR   = 4;

    typedef logic [COORD_BITS-1:0]       t_coord;
    typedef logic [LEN_BITS-1:0]         t_len;
    typedef logic signed [EXT_BITS-1:0]  t_ext;
    typedef logic [DIFF_BITS-1:0]        t_diff;
    typedef logic [SQ_BITS-1:0]          t_sq;
    typedef logic [R2_BITS-1:0]          t_r2;
    typedef logic [1:0]                  t_rel;

    localparam t_rel REL_DISJOINT = 2'd0;
    localparam t_rel REL_TOUCH    = 2'd1;
    localparam t_rel REL_OVERLAP  = 2'd2;

    typedef struct packed {
        logic ovl;
        logic tch;
    } t_hit;

    function automatic t_ext sext_coord(input t_coord v);
        return t_ext'(signed'({v[COORD_BITS-1], v}));
    endfunction

    function automatic t_diff abs_diff(input t_ext a, input t_ext b);
        logic signed [EXT_BITS:0] d;
        logic signed [EXT_BITS:0] m;
        d = {a[EXT_BITS-1], a} - {b[EXT_BITS-1], b};
        m = d[EXT_BITS] ? -d : d;
        return m[DIFF_BITS-1:0];
    endfunction

endpackage

// ----- rtl/core/csr_corner.sv -----
// ----------------------------------------------------------------------------
// Corner distance test
// Adds the squared axis distances of one square corner and compares the sum
// against the squared radius.
// ----------------------------------------------------------------------------
module csr_corner (
    input  csr_pkg::t_sq  i_sx,
    input  csr_pkg::t_sq  i_sy,
    input  csr_pkg::t_r2  i_r2,
    output csr_pkg::t_hit o_hit
);
    import csr_pkg::*;

    logic [DIST_BITS-1:0] dist_sum;
    logic [DIST_BITS-1:0] r2_ext;

    assign dist_sum  = {1'b0, i_sx} + {1'b0, i_sy};
    assign r2_ext    = DIST_BITS'(i_r2);
    assign o_hit.ovl = dist_sum < r2_ext;
    assign o_hit.tch = dist_sum == r2_ext;

endmodule

// ----- rtl/core/circle_square_relation_top.sv -----
// ----------------------------------------------------------------------------
// Circle and square relation classifier
// o_valid follows a taken start beat through the r_v1 to r_v4 stage valid bits.
// Throughput: one beat per cycle; busy stays low, the four register stages
// (extents, differences, squares, corner compare) are fully pipelined.
// Reset: synchronous active-low reset clears all stage valid bits.
// ----------------------------------------------------------------------------
module circle_square_relation_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  csr_pkg::t_coord i_circle_cx,
    input  csr_pkg::t_coord i_circle_cy,
    input  csr_pkg::t_len   i_radius,
    input  csr_pkg::t_coord i_square_x0,
    input  csr_pkg::t_coord i_square_y0,
    input  csr_pkg::t_len   i_side_len,
    output logic            o_valid,
    output csr_pkg::t_rel   o_relation
);
    import csr_pkg::*;

    // Stage 1: sign-extended coordinates and extents.
    logic  r_v1, n_v1;
    t_ext  r_cx, r_cy, r_x0, r_y0, r_x1, r_y1;
    t_ext  r_exl, r_exh, r_eyl, r_eyh;
    t_len  r_r;

    // Stage 2: axis distances, squared radius and point tests.
    logic  r_v2;
    t_diff r_dx0, r_dx1, r_dy0, r_dy1;
    t_r2   r_r2;
    t_hit  r_pt2;

    // Stage 3: squared axis distances.
    logic  r_v3;
    t_sq   r_sx0, r_sx1, r_sy0, r_sy1;
    t_r2   r_r2b;
    t_hit  r_pt3;

    // Stage 4: output register.
    logic  r_v4;
    t_rel  r_rel;

    t_ext  cx_e, cy_e, x0_e, y0_e;
    t_ext  rad_e, side_e;
    t_ext  px [NUM_PTS];
    t_ext  py [NUM_PTS];
    logic [NUM_PTS-1:0]  pt_in;
    logic [NUM_EXTR-1:0] pt_bd;
    t_hit  pt_hit;
    t_hit  hit_c [4];
    t_hit  corner_hit;
    t_rel  n_rel;

    assign busy   = 1'b0;
    assign n_v1   = start && !busy;
    assign cx_e   = sext_coord(i_circle_cx);
    assign cy_e   = sext_coord(i_circle_cy);
    assign x0_e   = sext_coord(i_square_x0);
    assign y0_e   = sext_coord(i_square_y0);
    assign rad_e  = t_ext'({2'b00, i_radius});
    assign side_e = t_ext'({2'b00, i_side_len});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx  <= cx_e;
        r_cy  <= cy_e;
        r_x0  <= x0_e;
        r_y0  <= y0_e;
        r_x1  <= x0_e + side_e;
        r_y1  <= y0_e + side_e;
        r_exl <= cx_e - rad_e;
        r_exh <= cx_e + rad_e;
        r_eyl <= cy_e - rad_e;
        r_eyh <= cy_e + rad_e;
        r_r   <= i_radius;
    end

    always_comb begin
        px[0] = r_exl; py[0] = r_cy;
        px[1] = r_exh; py[1] = r_cy;
        px[2] = r_cx;  py[2] = r_eyl;
        px[3] = r_cx;  py[3] = r_eyh;
        px[4] = r_cx;  py[4] = r_cy;
        for (int i = 0; i < NUM_PTS; i++) begin
            pt_in[i] = (px[i] > r_x0) && (px[i] < r_x1) &&
                       (py[i] > r_y0) && (py[i] < r_y1);
        end
        for (int i = 0; i < NUM_EXTR; i++) begin
            pt_bd[i] = (((px[i] == r_x0) || (px[i] == r_x1)) &&
                        (py[i] >= r_y0) && (py[i] <= r_y1)) ||
                       (((py[i] == r_y0) || (py[i] == r_y1)) &&
                        (px[i] >= r_x0) && (px[i] <= r_x1));
        end
        pt_hit.ovl = |pt_in;
        pt_hit.tch = |pt_bd;
    end

    always_ff @(posedge i_clk) begin
        r_dx0 <= abs_diff(r_x0, r_cx);
        r_dx1 <= abs_diff(r_x1, r_cx);
        r_dy0 <= abs_diff(r_y0, r_cy);
        r_dy1 <= abs_diff(r_y1, r_cy);
        r_r2  <= R2_BITS'(r_r) * R2_BITS'(r_r);
        r_pt2 <= pt_hit;
    end

    always_ff @(posedge i_clk) begin
        r_sx0 <= SQ_BITS'(r_dx0) * SQ_BITS'(r_dx0);
        r_sx1 <= SQ_BITS'(r_dx1) * SQ_BITS'(r_dx1);
        r_sy0 <= SQ_BITS'(r_dy0) * SQ_BITS'(r_dy0);
        r_sy1 <= SQ_BITS'(r_dy1) * SQ_BITS'(r_dy1);
        r_r2b <= r_r2;
        r_pt3 <= r_pt2;
    end

    csr_corner u_corner0 (.i_sx(r_sx0), .i_sy(r_sy0), .i_r2(r_r2b), .o_hit(hit_c[0]));
    csr_corner u_corner1 (.i_sx(r_sx1), .i_sy(r_sy0), .i_r2(r_r2b), .o_hit(hit_c[1]));
    csr_corner u_corner2 (.i_sx(r_sx0), .i_sy(r_sy1), .i_r2(r_r2b), .o_hit(hit_c[2]));
    csr_corner u_corner3 (.i_sx(r_sx1), .i_sy(r_sy1), .i_r2(r_r2b), .o_hit(hit_c[3]));

    always_comb begin
        corner_hit.ovl = hit_c[0].ovl | hit_c[1].ovl | hit_c[2].ovl | hit_c[3].ovl;
        corner_hit.tch = hit_c[0].tch | hit_c[1].tch | hit_c[2].tch | hit_c[3].tch;
        if (corner_hit.ovl || r_pt3.ovl) begin
            n_rel = REL_OVERLAP;
        end else if (corner_hit.tch || r_pt3.tch) begin
            n_rel = REL_TOUCH;
        end else begin
            n_rel = REL_DISJOINT;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rel <= n_rel;
    end

    assign o_valid    = r_v4;
    assign o_relation = r_rel;

endmodule

// ----- rtl/core/csr_checker.sv -----
// ----------------------------------------------------------------------------
// Circle and square relation checker
// Port-level timing and code checks for the classifier, bound to the top
// level.
// ----------------------------------------------------------------------------
module csr_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_valid,
    input csr_pkg::t_rel o_relation
);
    import csr_pkg::*;

    // Every accepted beat yields its result once through the stage registers.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_valid)
        else $error("result missing four cycles after accepted beat");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 4))
        else $error("result without matching accepted beat");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_relation == REL_DISJOINT || o_relation == REL_TOUCH ||
                     o_relation == REL_OVERLAP))
        else $error("illegal relation code");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised on a fully pipelined block");

endmodule

bind circle_square_relation_top csr_checker u_csr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_valid    (o_valid),
    .o_relation (o_relation)
);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle and square relation testbench
// Drives circle and square queries into the classifier, some directed at the
// point-like and boundary cases and the rest random with a bias toward
// touching geometry. A scoreboard predicts each relation code and checks every
// result beat in order against it.
// ----------------------------------------------------------------------------
class relation_scoreboard;
    csr_pkg::t_rel pending_relations[$];
    int            error_count;
    int            query_count;
    int            seen_count[4];

    function void note_query(csr_pkg::t_coord cx_b, csr_pkg::t_coord cy_b,
                             csr_pkg::t_len r_b, csr_pkg::t_coord x0_b,
                             csr_pkg::t_coord y0_b, csr_pkg::t_len s_b);
        longint cx, cy, r, x0, y0, s, r2, dx, dy, dsq, x1, y1;
        longint kx[4], ky[4], ex[5], ey[5];
        bit     ovl, tch, in_x, in_y;
        cx = longint'($signed(cx_b));
        cy = longint'($signed(cy_b));
        r  = longint'(r_b);
        x0 = longint'($signed(x0_b));
        y0 = longint'($signed(y0_b));
        s  = longint'(s_b);
        r2 = r * r;
        x1 = x0 + s;
        y1 = y0 + s;
        ovl = 1'b0;
        tch = 1'b0;
        kx[0] = x0; ky[0] = y0;
        kx[1] = x1; ky[1] = y0;
        kx[2] = x0; ky[2] = y1;
        kx[3] = x1; ky[3] = y1;
        ex[0] = cx - r; ey[0] = cy;
        ex[1] = cx + r; ey[1] = cy;
        ex[2] = cx;     ey[2] = cy - r;
        ex[3] = cx;     ey[3] = cy + r;
        ex[4] = cx;     ey[4] = cy;
        for (int i = 0; i < 4; i++) begin
            dx = kx[i] - cx;
            dy = ky[i] - cy;
            dsq = dx * dx + dy * dy;
            if (dsq < r2) ovl = 1'b1;
            if (dsq == r2) tch = 1'b1;
        end
        for (int i = 0; i < 5; i++) begin
            if (ex[i] > x0 && ex[i] < x1 && ey[i] > y0 && ey[i] < y1) ovl = 1'b1;
        end
        // The center is not a border sample, only the four extreme points are.
        for (int i = 0; i < 4; i++) begin
            in_x = ex[i] >= x0 && ex[i] <= x1;
            in_y = ey[i] >= y0 && ey[i] <= y1;
            if (((ex[i] == x0 || ex[i] == x1) && in_y) ||
                ((ey[i] == y0 || ey[i] == y1) && in_x)) tch = 1'b1;
        end
        query_count++;
        pending_relations.push_back(ovl ? csr_pkg::REL_OVERLAP :
                                    tch ? csr_pkg::REL_TOUCH : csr_pkg::REL_DISJOINT);
    endfunction

    function void check_relation(csr_pkg::t_rel got);
        csr_pkg::t_rel want_rel;
        if (pending_relations.size() == 0) begin
            $error("relation beat with no query outstanding: actual %0d", got);
            error_count++;
        end else begin
            want_rel = pending_relations.pop_front();
            if (got !== want_rel) begin
                $error("relation mismatch: expected %0d, actual %0d", want_rel, got);
                error_count++;
            end else begin
                seen_count[got]++;
            end
        end
    endfunction
endclass

module testbench;
    import csr_pkg::*;

    localparam int STALL_LIMIT = 200;
    localparam int DRAIN_CYCLES = 8;

    logic   i_clk = 1'b0;
    logic   i_rst_n;
    logic   start;
    logic   busy;
    t_coord i_circle_cx;
    t_coord i_circle_cy;
    t_len   i_radius;
    t_coord i_square_x0;
    t_coord i_square_y0;
    t_len   i_side_len;
    logic   o_valid;
    t_rel   o_relation;

    int stall_cycles = 0;

    relation_scoreboard board = new;

    circle_square_relation_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_circle_cx (i_circle_cx),
        .i_circle_cy (i_circle_cy),
        .i_radius    (i_radius),
        .i_square_x0 (i_square_x0),
        .i_square_y0 (i_square_y0),
        .i_side_len  (i_side_len),
        .o_valid     (o_valid),
        .o_relation  (o_relation)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                board.check_relation(o_relation);
            end else if (o_valid !== 1'b0) begin
                $error("result strobe unknown: expected 0, actual %b", o_valid);
                board.error_count++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid === 1'b1) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("no progress for %0d cycles", STALL_LIMIT);
                $display("testbench: done, errors");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    task automatic send_query(input int cx, input int cy, input int r, input int x0,
                              input int y0, input int s, input bit allow_idle);
        i_circle_cx <= t_coord'(cx);
        i_circle_cy <= t_coord'(cy);
        i_radius    <= t_len'(r);
        i_square_x0 <= t_coord'(x0);
        i_square_y0 <= t_coord'(y0);
        i_side_len  <= t_len'(s);
        start       <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        board.note_query(t_coord'(cx), t_coord'(cy), t_len'(r), t_coord'(x0),
                         t_coord'(y0), t_len'(s));
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic send_random(input bit allow_idle);
        int bx, by, rr, ss, ofs, ta, tb, tc, k, px, py, cx, cy;
        int edge_coord[5];
        int edge_len[4];
        edge_coord = '{-32768, -1, 0, 1, 32767};
        edge_len = '{0, 1, 16384, 32767};
        bx = int'($urandom_range(0, 64000)) - 32000;
        by = int'($urandom_range(0, 64000)) - 32000;
        case ($urandom_range(0, 9))
            0, 1: begin
                send_query($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           allow_idle);
            end
            2, 3: begin
                ss = $urandom_range(0, 40);
                rr = $urandom_range(0, 40);
                send_query(bx + int'($urandom_range(0, 100)) - 30,
                           by + int'($urandom_range(0, 100)) - 30,
                           rr, bx, by, ss, allow_idle);
            end
            4, 5: begin
                ss = $urandom_range(0, 60);
                rr = $urandom_range(0, 60);
                ofs = $urandom_range(0, ss);
                case ($urandom_range(0, 3))
                    0: send_query(bx - rr, by + ofs, rr, bx, by, ss, allow_idle);
                    1: send_query(bx + ss + rr, by + ofs, rr, bx, by, ss, allow_idle);
                    2: send_query(bx + ofs, by - rr, rr, bx, by, ss, allow_idle);
                    default: send_query(bx + ofs, by + ss + rr, rr, bx, by, ss,
                                        allow_idle);
                endcase
            end
            6, 7: begin
                case ($urandom_range(0, 3))
                    0: begin ta = 3; tb = 4; tc = 5; end
                    1: begin ta = 5; tb = 12; tc = 13; end
                    2: begin ta = 8; tb = 15; tc = 17; end
                    default: begin ta = 0; tb = 1; tc = 1; end
                endcase
                if ($urandom_range(0, 1)) begin
                    k = ta; ta = tb; tb = k;
                end
                k = $urandom_range(1, 20);
                ss = $urandom_range(0, 200);
                px = bx + ($urandom_range(0, 1) ? ss : 0);
                py = by + ($urandom_range(0, 1) ? ss : 0);
                cx = px + ($urandom_range(0, 1) ? ta * k : -ta * k);
                cy = py + ($urandom_range(0, 1) ? tb * k : -tb * k);
                send_query(cx, cy, tc * k, bx, by, ss, allow_idle);
            end
            8: begin
                send_query(edge_coord[$urandom_range(0, 4)], edge_coord[$urandom_range(0, 4)],
                           edge_len[$urandom_range(0, 3)], edge_coord[$urandom_range(0, 4)],
                           edge_coord[$urandom_range(0, 4)], edge_len[$urandom_range(0, 3)],
                           allow_idle);
            end
            default: begin
                rr = $urandom_range(0, 32767);
                ss = $urandom_range(0, 32767);
                send_query(bx + int'($urandom_range(0, 2 * rr + ss)) - rr,
                           by + int'($urandom_range(0, 2 * rr + ss)) - rr,
                           rr, bx, by, ss, allow_idle);
            end
        endcase
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_circle_cx = '0;
        i_circle_cy = '0;
        i_radius    = '0;
        i_square_x0 = '0;
        i_square_y0 = '0;
        i_side_len  = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_query(0, 0, 0, 0, 0, 0, 1'b1);
        send_query(15, 15, 0, 5, 5, 10, 1'b1);
        send_query(7, 7, 0, 0, 0, 10, 1'b1);
        send_query(10, 0, 0, 0, 0, 10, 1'b1);
        send_query(0, 0, 5, 5, 0, 0, 1'b1);
        send_query(0, 0, 5, 3, 4, 0, 1'b1);
        send_query(0, 0, 5, 1, 1, 0, 1'b1);
        send_query(0, 0, 5, 3, 4, 10, 1'b1);
        send_query(0, 0, 10, 10, -5, 10, 1'b1);
        send_query(0, 0, 10, 5, -2, 10, 1'b1);
        send_query(100, 100, 5, 0, 0, 20, 1'b1);
        send_query(0, 0, 1000, -10, -10, 20, 1'b1);
        send_query(50, 50, 5, 0, 0, 100, 1'b1);
        send_query(50, -5, 10, 0, 0, 100, 1'b1);
        send_query(-32768, -32768, 32767, 32767, 32767, 32767, 1'b1);
        send_query(32767, 32767, 32767, -32768, -32768, 32767, 1'b1);
        send_query(-32768, 32767, 32767, -32768, -32768, 32767, 1'b1);
        send_query(32767, -32768, 0, 32767, -32768, 0, 1'b1);
        send_query(-1, -1, 1, 0, 0, 1, 1'b1);
        send_query(0, 0, 32767, 0, 0, 32767, 1'b1);
        send_query(-32768, -32768, 32767, -32768, -32768, 32767, 1'b1);
        send_query(32767, 32767, 1, 32767, 32767, 32767, 1'b1);
        send_query(32767, 0, 32767, -32768, -16384, 32767, 1'b1);
        send_query(-32768, 0, 32767, -1, -1, 0, 1'b1);

        repeat (750) send_random(1'b1);
        repeat (150) send_random(1'b0);
        start <= 1'b0;

        while (board.pending_relations.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d queries, point-like and edge-value cases included", board.query_count);
        $display("relations seen: %0d disjoint, %0d touching, %0d overlapping",
                 board.seen_count[REL_DISJOINT], board.seen_count[REL_TOUCH],
                 board.seen_count[REL_OVERLAP]);
        if (board.error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule
